FILE: design/v3c_ssd_pkg.sv
// Package for the V3C sample stream deframer: parse phases, event kinds,
// unit type codes and the result word struct. No dependencies.
package v3c_ssd_pkg;

    typedef enum logic [2:0] {
        PH_STREAM,
        PH_USIZE,
        PH_UHDR,
        PH_SKIP,
        PH_NPREC,
        PH_NSIZE,
        PH_NFIRST,
        PH_NPAY
    } v3c_phase_t;

    localparam logic [1:0] KIND_HDR       = 2'd0;
    localparam logic [1:0] KIND_PSET      = 2'd1;
    localparam logic [1:0] KIND_NAL       = 2'd2;
    localparam logic [1:0] KIND_MALFORMED = 2'd3;

    localparam logic [4:0] UT_VPS = 5'd0;
    localparam logic [4:0] UT_AD  = 5'd1;
    localparam logic [4:0] UT_GVD = 5'd3;
    localparam logic [4:0] UT_AVD = 5'd4;
    localparam logic [4:0] UT_PVD = 5'd5;
    localparam logic [4:0] UT_CAD = 5'd6;

    // video units use a fixed NAL size field before capping
    localparam logic [3:0] VIDEO_NAL_PREC = 4'd4;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [5:0]  nal_type;
        logic [4:0]  partition_index;
        logic [6:0]  attribute_index;
        logic        aux_flag;
        logic [3:0]  map_idx;
        logic [5:0]  atlas_idx;
        logic [3:0]  ps_id;
        logic [4:0]  v3c_type;
        logic [63:0] length;
        logic [47:0] byte_offset;
    } v3c_event_t;

endpackage

FILE: design/v3c_sample_stream_deframer.sv
// V3C sample stream deframer, top level: byte stream in, unit/NAL events out.
// An event word is formed from the input register and offered from the result register.
// Takes one byte word per cycle while the output buffer's skid entry is free.
// A two-entry output buffer keeps input flowing while an event word waits.
// Reset (rst_n low, asynchronous): parser expects a stream header, offset zero.
// Depends on v3c_ssd_pkg, v3c_ssd_parser and v3c_ssd_skid.
module v3c_sample_stream_deframer #(
    parameter int OFFSET_BITS    = 48,  // stream offset counter width, 16..64
    parameter int MAX_SIZE_BYTES = 8    // cap on size field precision, 1..8
) (
    input  logic         clk,
    input  logic         rst_n,
    // byte stream in
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,    // [7:0] data_byte
    input  logic         s_tlast,    // last_byte: end of stream
    // event stream out
    output logic         m_tvalid,
    input  logic         m_tready,
    // [47:0] byte_offset, [111:48] length, [116:112] v3c_type,
    // [120:117] ps_id, [126:121] atlas_idx, [130:127] map_idx,
    // [131] aux_flag, [138:132] attribute_index,
    // [143:139] partition_index, [149:144] nal_type, [151:150] zero
    output logic [151:0] m_tdata,
    output logic [1:0]   m_tuser     // [1:0] event_kind
);
    import v3c_ssd_pkg::*;

    logic       ev_valid;
    logic       ev_ready;
    v3c_event_t ev_data;
    v3c_event_t out_ev;

    // phase machine and counters; forms at most one event word per byte
    v3c_ssd_parser #(
        .OFFSET_BITS    (OFFSET_BITS),
        .MAX_SIZE_BYTES (MAX_SIZE_BYTES)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .ev_valid (ev_valid),
        .ev_ready (ev_ready),
        .ev_data  (ev_data)
    );

    // result register with skid entry
    v3c_ssd_skid u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (ev_valid),
        .push_ready (ev_ready),
        .push_data  (ev_data),
        .pop_valid  (m_tvalid),
        .pop_ready  (m_tready),
        .pop_data   (out_ev)
    );

    // event kind travels in tuser, everything else packed into tdata
    assign m_tuser = out_ev.event_kind;
    assign m_tdata = {2'b00,
                      out_ev.nal_type,
                      out_ev.partition_index,
                      out_ev.attribute_index,
                      out_ev.aux_flag,
                      out_ev.map_idx,
                      out_ev.atlas_idx,
                      out_ev.ps_id,
                      out_ev.v3c_type,
                      out_ev.length,
                      out_ev.byte_offset};

endmodule

FILE: design/v3c_ssd_parser.sv
// Byte parser: input register, phase machine and size/offset counters.
// Forms at most one event word per byte. Uses v3c_ssd_pkg.
module v3c_ssd_parser #(
    parameter int OFFSET_BITS    = 48,
    parameter int MAX_SIZE_BYTES = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_byte,
    input  logic                   in_last,
    output logic                   ev_valid,
    input  logic                   ev_ready,
    output v3c_ssd_pkg::v3c_event_t ev_data
);
    import v3c_ssd_pkg::*;

    localparam int SIZE_BITS = 8 * MAX_SIZE_BYTES;
    localparam logic [3:0] MAX_PREC = 4'(MAX_SIZE_BYTES);

    function automatic logic [3:0] cap_prec(input logic [3:0] p);
        return (p > MAX_PREC) ? MAX_PREC : p;
    endfunction

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // parse state
    v3c_phase_t             phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [3:0]             uprec_reg, uprec_next;
    logic [3:0]             nprec_reg, nprec_next;
    logic [SIZE_BITS-1:0]   acc_reg, acc_next;
    logic [3:0]             fcount_reg, fcount_next;
    logic [SIZE_BITS-1:0]   unit_rem_reg, unit_rem_next;
    logic [SIZE_BITS-1:0]   nal_rem_reg, nal_rem_next;
    logic [31:0]            hdr_reg, hdr_next;
    logic [4:0]             type_reg, type_next;
    logic [SIZE_BITS-1:0]   unit_size_reg, unit_size_next;
    logic [OFFSET_BITS-1:0] unit_start_reg, unit_start_next;

    logic                   fire;
    logic [OFFSET_BITS-1:0] off_p1;
    logic [SIZE_BITS-1:0]   acc_shift;
    logic                   emit;
    logic [1:0]             emit_kind;
    logic [OFFSET_BITS-1:0] emit_off;
    logic [SIZE_BITS-1:0]   emit_len;
    logic                   emit_fields;
    logic [5:0]             emit_ntype;
    logic [7:0]             b0, b1, b2, b3;

    assign fire      = in_valid_reg && ev_ready;
    assign in_ready  = !in_valid_reg || ev_ready;
    assign off_p1    = offset_reg + OFFSET_BITS'(1);
    assign acc_shift = (acc_reg << 8) | SIZE_BITS'(in_byte_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= in_byte;
            in_last_reg <= in_last;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        offset_next     = offset_reg;
        uprec_next      = uprec_reg;
        nprec_next      = nprec_reg;
        acc_next        = acc_reg;
        fcount_next     = fcount_reg;
        unit_rem_next   = unit_rem_reg;
        nal_rem_next    = nal_rem_reg;
        hdr_next        = hdr_reg;
        type_next       = type_reg;
        unit_size_next  = unit_size_reg;
        unit_start_next = unit_start_reg;
        emit        = 1'b0;
        emit_kind   = KIND_HDR;
        emit_off    = unit_start_reg;
        emit_len    = unit_size_reg;
        emit_fields = 1'b0;
        emit_ntype  = 6'd0;

        unique case (phase_reg)
            PH_USIZE:
            begin
                acc_next    = acc_shift;
                fcount_next = fcount_reg + 4'd1;
                if (fcount_next >= uprec_reg)
                begin
                    unit_size_next  = acc_shift;
                    unit_rem_next   = acc_shift;
                    unit_start_next = off_p1;
                    hdr_next        = 32'd0;
                    type_next       = 5'd0;
                    fcount_next     = 4'd0;
                    if (acc_shift == '0)
                    begin
                        emit      = 1'b1;
                        emit_kind = KIND_MALFORMED;
                        emit_off  = off_p1;
                        emit_len  = '0;
                        acc_next  = '0;
                    end
                    else
                    begin
                        phase_next = PH_UHDR;
                    end
                end
            end
            PH_UHDR:
            begin
                hdr_next      = {hdr_reg[23:0], in_byte_reg};
                fcount_next   = fcount_reg + 4'd1;
                unit_rem_next = unit_rem_reg - SIZE_BITS'(1);
                if (fcount_next == 4'd1)
                begin
                    type_next = in_byte_reg[7:3];
                end
                if (fcount_next >= 4'd4)
                begin
                    fcount_next = 4'd0;
                    emit        = 1'b1;
                    if (type_next == UT_VPS)
                    begin
                        emit_kind = KIND_PSET;
                        if (unit_rem_next != '0)
                        begin
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            phase_next = PH_USIZE;
                            acc_next   = '0;
                        end
                    end
                    else if (type_next == UT_AD || type_next == UT_CAD)
                    begin
                        if (unit_rem_next == '0)
                        begin
                            emit_kind  = KIND_MALFORMED;
                            phase_next = PH_USIZE;
                            acc_next   = '0;
                        end
                        else
                        begin
                            emit_kind   = KIND_HDR;
                            emit_fields = 1'b1;
                            phase_next  = PH_NPREC;
                        end
                    end
                    else
                    begin
                        nprec_next  = cap_prec(VIDEO_NAL_PREC);
                        emit_kind   = KIND_HDR;
                        emit_fields = 1'b1;
                        acc_next    = '0;
                        phase_next  = (unit_rem_next != '0) ? PH_NSIZE : PH_USIZE;
                    end
                end
                else if (unit_rem_next == '0)
                begin
                    // unit ends inside its header
                    emit        = 1'b1;
                    emit_kind   = KIND_MALFORMED;
                    phase_next  = PH_USIZE;
                    acc_next    = '0;
                    fcount_next = 4'd0;
                end
            end
            PH_SKIP:
            begin
                unit_rem_next = unit_rem_reg - SIZE_BITS'(1);
                if (unit_rem_next == '0)
                begin
                    phase_next  = PH_USIZE;
                    acc_next    = '0;
                    fcount_next = 4'd0;
                end
            end
            PH_NPREC:
            begin
                nprec_next    = cap_prec({1'b0, in_byte_reg[7:5]} + 4'd1);
                unit_rem_next = unit_rem_reg - SIZE_BITS'(1);
                phase_next    = (unit_rem_next != '0) ? PH_NSIZE : PH_USIZE;
                acc_next      = '0;
                fcount_next   = 4'd0;
            end
            PH_NSIZE:
            begin
                acc_next      = acc_shift;
                fcount_next   = fcount_reg + 4'd1;
                unit_rem_next = unit_rem_reg - SIZE_BITS'(1);
                if (fcount_next >= nprec_reg)
                begin
                    acc_next    = '0;
                    fcount_next = 4'd0;
                    if (acc_shift == '0 || unit_rem_next == '0)
                    begin
                        // empty NAL, or size field on the unit's last byte
                        emit        = 1'b1;
                        emit_kind   = KIND_NAL;
                        emit_off    = off_p1;
                        emit_len    = acc_shift;
                        emit_fields = 1'b1;
                        if (unit_rem_next == '0)
                        begin
                            phase_next = PH_USIZE;
                        end
                    end
                    else
                    begin
                        nal_rem_next = acc_shift;
                        phase_next   = PH_NFIRST;
                    end
                end
                else if (unit_rem_next == '0)
                begin
                    // truncated NAL size field
                    emit        = 1'b1;
                    emit_kind   = KIND_MALFORMED;
                    phase_next  = PH_USIZE;
                    acc_next    = '0;
                    fcount_next = 4'd0;
                end
            end
            PH_NFIRST, PH_NPAY:
            begin
                if (phase_reg == PH_NFIRST)
                begin
                    emit        = 1'b1;
                    emit_kind   = KIND_NAL;
                    emit_off    = offset_reg;
                    emit_len    = nal_rem_reg;
                    emit_fields = 1'b1;
                    emit_ntype  = in_byte_reg[6:1];
                end
                nal_rem_next  = nal_rem_reg - SIZE_BITS'(1);
                unit_rem_next = unit_rem_reg - SIZE_BITS'(1);
                if (unit_rem_next == '0)
                begin
                    phase_next  = PH_USIZE;
                    acc_next    = '0;
                    fcount_next = 4'd0;
                end
                else if (nal_rem_next == '0)
                begin
                    phase_next  = PH_NSIZE;
                    acc_next    = '0;
                    fcount_next = 4'd0;
                end
                else
                begin
                    phase_next = PH_NPAY;
                end
            end
            default:
            begin
                // stream header byte
                uprec_next  = cap_prec({1'b0, in_byte_reg[7:5]} + 4'd1);
                phase_next  = PH_USIZE;
                acc_next    = '0;
                fcount_next = 4'd0;
            end
        endcase

        offset_next = off_p1;
        if (in_last_reg)
        begin
            phase_next  = PH_STREAM;
            offset_next = '0;
            acc_next    = '0;
            fcount_next = 4'd0;
        end
    end

    // unit header field decode, from the header as updated by this byte
    assign b0 = hdr_next[31:24];
    assign b1 = hdr_next[23:16];
    assign b2 = hdr_next[15:8];
    assign b3 = hdr_next[7:0];

    always_comb
    begin
        ev_data                 = '0;
        ev_data.event_kind      = emit_kind;
        ev_data.byte_offset     = 48'(emit_off);
        ev_data.length          = 64'(emit_len);
        ev_data.v3c_type        = type_next;
        ev_data.nal_type        = emit_ntype;
        if (emit_fields)
        begin
            if (type_next >= UT_AD && type_next <= UT_CAD)
            begin
                ev_data.ps_id = {b0[2:0], b1[7]};
            end
            if (type_next >= UT_AD && type_next <= UT_PVD)
            begin
                ev_data.atlas_idx = b1[6:1];
            end
            if (type_next == UT_GVD)
            begin
                ev_data.map_idx  = {b1[0], b2[7:5]};
                ev_data.aux_flag = b2[4];
            end
            else if (type_next == UT_AVD)
            begin
                ev_data.attribute_index = {b1[0], b2[7:2]};
                ev_data.partition_index = {b2[1:0], b3[7:5]};
                ev_data.map_idx         = b3[4:1];
                ev_data.aux_flag        = b3[0];
            end
        end
    end

    assign ev_valid = fire && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_STREAM;
            offset_reg     <= '0;
            uprec_reg      <= 4'd1;
            nprec_reg      <= cap_prec(VIDEO_NAL_PREC);
            acc_reg        <= '0;
            fcount_reg     <= 4'd0;
            unit_rem_reg   <= '0;
            nal_rem_reg    <= '0;
            hdr_reg        <= 32'd0;
            type_reg       <= 5'd0;
            unit_size_reg  <= '0;
            unit_start_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            offset_reg     <= offset_next;
            uprec_reg      <= uprec_next;
            nprec_reg      <= nprec_next;
            acc_reg        <= acc_next;
            fcount_reg     <= fcount_next;
            unit_rem_reg   <= unit_rem_next;
            nal_rem_reg    <= nal_rem_next;
            hdr_reg        <= hdr_next;
            type_reg       <= type_next;
            unit_size_reg  <= unit_size_next;
            unit_start_reg <= unit_start_next;
        end
    end

endmodule

FILE: design/v3c_ssd_skid.sv
// Two-entry output buffer for event words: result register plus skid.
// Ready toward the parser is registered. Uses v3c_ssd_pkg.
module v3c_ssd_skid (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push_valid,
    output logic                    push_ready,
    input  v3c_ssd_pkg::v3c_event_t push_data,
    output logic                    pop_valid,
    input  logic                    pop_ready,
    output v3c_ssd_pkg::v3c_event_t pop_data
);
    import v3c_ssd_pkg::*;

    logic       main_valid_reg;
    logic       skid_valid_reg;
    v3c_event_t main_reg;
    v3c_event_t skid_reg;
    logic       pop;

    assign pop        = main_valid_reg && pop_ready;
    assign push_ready = !skid_valid_reg;
    assign pop_valid  = main_valid_reg;
    assign pop_data   = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push_valid)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            main_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (push_valid)
        begin
            if (!main_valid_reg || pop)
            begin
                main_reg <= push_data;
            end
            else
            begin
                skid_reg <= push_data;
            end
        end
    end

endmodule

FILE: design/v3c_ssd_checker.sv
// Port-level checks for the V3C sample stream deframer, bound to the top.
// Depends on v3c_ssd_pkg and v3c_sample_stream_deframer.
module v3c_ssd_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [151:0] m_tdata,
    input logic [1:0]   m_tuser
);
    import v3c_ssd_pkg::*;

    // stalled event word stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("event word dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("event word changed while stalled");

    // no event word right after a reset cycle
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("event word offered after reset");

    // only NAL events carry a NAL type
    a_ntype_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != KIND_NAL) |-> m_tdata[149:144] == 6'd0)
        else $error("nal_type set on non-NAL event");

    // parameter set and malformed events carry only the unit type, length and byte offset
    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_PSET || m_tuser == KIND_MALFORMED)
        |-> m_tdata[143:117] == 27'd0)
        else $error("header fields set on parameter set or malformed event");

endmodule

bind v3c_sample_stream_deframer v3c_ssd_checker u_v3c_ssd_checker (.*);
